>>> hw/rtl/bir_pkg.sv
package bir_pkg;

    localparam int COORD_W   = 12;
    localparam int STEP_W    = 24;
    localparam int CH_W      = 8;
    localparam int SIDE_W    = 9;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = COORD_W + STEP_W;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel;
    } item_t;

    typedef struct packed {
        logic [SIDE_W-1:0] src_width;
        logic [SIDE_W-1:0] src_height;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
    } cfg_t;

endpackage

>>> hw/rtl/bir_front.sv
module bir_front
    import bir_pkg::*;
#(
    parameter int MAX_SRC_SIDE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [COORD_W-1:0] pos_col,
    input  logic [COORD_W-1:0] pos_row,
    input  logic [CH_W-1:0]    in_red,
    input  logic [CH_W-1:0]    in_green,
    input  logic [CH_W-1:0]    in_blue,
    output logic               q_valid,
    input  logic               q_ready,
    output item_t              q_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    item_t            queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             keep;
    logic             push;
    logic             pop;
    item_t            new_item;

    // loads outside the store are dropped here
    always_comb
    begin
        keep = (kind == OP_REQ) ||
               ((32'(pos_col) < MAX_SRC_SIDE) && (32'(pos_row) < MAX_SRC_SIDE));
        new_item.op    = kind;
        new_item.col   = pos_col;
        new_item.row   = pos_row;
        new_item.pixel = {in_red, in_green, in_blue};
    end

    assign in_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready && keep;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> hw/rtl/bir_back.sv
module bir_back
    import bir_pkg::*;
#(
    parameter int MAX_SRC_SIDE = 256,
    parameter int FRAC_BITS    = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  item_t           q_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CH_W-1:0] out_red,
    output logic [CH_W-1:0] out_green,
    output logic [CH_W-1:0] out_blue
);

    localparam int F     = FRAC_BITS;
    localparam int XW    = $clog2(MAX_SRC_SIDE);
    localparam int SW    = $clog2(MAX_SRC_SIDE + 1);
    localparam int HALF  = (MAX_SRC_SIDE + 1) / 2;
    localparam int HW    = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int BDEP  = 1 << (2 * HW);
    localparam int IXW   = POS_W - F;
    localparam int WW    = 2 * F + 2;
    localparam int PRW   = WW + CH_W;
    localparam int SUMW  = PRW + 2;

    logic en;

    // stage 1: source position products
    logic             p1_valid_reg;
    logic             p1_op_reg;
    logic [POS_W-1:0] p1_px_reg;
    logic [POS_W-1:0] p1_py_reg;
    logic [XW-1:0]    p1_col_reg;
    logic [XW-1:0]    p1_row_reg;
    logic [PIX_W-1:0] p1_pix_reg;

    // stage 2: neighbor addresses and fractions
    logic             p2_valid_reg;
    logic             p2_op_reg;
    logic [HW-1:0]    p2_hc_reg [2];
    logic [HW-1:0]    p2_hr_reg [2];
    logic             p2_x0p_reg, p2_x1p_reg, p2_y0p_reg, p2_y1p_reg;
    logic [F-1:0]     p2_fx_reg, p2_fy_reg;
    logic [1:0]       p2_wbank_reg;
    logic [2*HW-1:0]  p2_waddr_reg;
    logic [PIX_W-1:0] p2_pix_reg;

    // stage 3: store data and weights
    logic             p3_valid_reg;
    logic             p3_req_reg;
    logic             p3_x0p_reg, p3_x1p_reg, p3_y0p_reg, p3_y1p_reg;
    logic [WW-1:0]    p3_wa_reg, p3_wb_reg, p3_wc_reg, p3_wd_reg;
    logic [PIX_W-1:0] rd_reg [4];

    // stage 4: weighted channels
    logic             p4_valid_reg;
    logic [PRW-1:0]   p4_prod_reg [3][4];

    logic             out_valid_reg;
    logic [CH_W-1:0]  out_r_reg, out_g_reg, out_b_reg;

    assign en      = !out_valid_reg || out_ready;
    assign q_ready = en;

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_op_reg  <= q_item.op;
            p1_px_reg  <= POS_W'(q_item.col * cfg.step_x);
            p1_py_reg  <= POS_W'(q_item.row * cfg.step_y);
            p1_col_reg <= XW'(q_item.col);
            p1_row_reg <= XW'(q_item.row);
            p1_pix_reg <= q_item.pixel;
        end
    end

    // stage 2: clamp to the source edge
    logic [SW-1:0]  w_eff, h_eff;
    logic [XW-1:0]  wm1, hm1;
    logic [IXW-1:0] ix, iy;
    logic [XW-1:0]  x0, x1, y0, y1;

    always_comb
    begin
        if (32'(cfg.src_width) > MAX_SRC_SIDE)
            w_eff = SW'(MAX_SRC_SIDE);
        else if (cfg.src_width == '0)
            w_eff = SW'(1);
        else
            w_eff = SW'(cfg.src_width);
        if (32'(cfg.src_height) > MAX_SRC_SIDE)
            h_eff = SW'(MAX_SRC_SIDE);
        else if (cfg.src_height == '0)
            h_eff = SW'(1);
        else
            h_eff = SW'(cfg.src_height);
        wm1 = XW'(w_eff - SW'(1));
        hm1 = XW'(h_eff - SW'(1));
        ix  = p1_px_reg[POS_W-1:F];
        iy  = p1_py_reg[POS_W-1:F];
        x0  = (ix >= IXW'(wm1)) ? wm1 : XW'(ix);
        y0  = (iy >= IXW'(hm1)) ? hm1 : XW'(iy);
        x1  = ((SW'(x0) + SW'(1)) < w_eff) ? XW'(x0 + 1'b1) : wm1;
        y1  = ((SW'(y0) + SW'(1)) < h_eff) ? XW'(y0 + 1'b1) : hm1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_op_reg    <= p1_op_reg;
            p2_hc_reg[0] <= (x0[0] == 1'b0) ? HW'(x0 >> 1) : HW'(x1 >> 1);
            p2_hc_reg[1] <= (x0[0] == 1'b1) ? HW'(x0 >> 1) : HW'(x1 >> 1);
            p2_hr_reg[0] <= (y0[0] == 1'b0) ? HW'(y0 >> 1) : HW'(y1 >> 1);
            p2_hr_reg[1] <= (y0[0] == 1'b1) ? HW'(y0 >> 1) : HW'(y1 >> 1);
            p2_x0p_reg   <= x0[0];
            p2_x1p_reg   <= x1[0];
            p2_y0p_reg   <= y0[0];
            p2_y1p_reg   <= y1[0];
            p2_fx_reg    <= p1_px_reg[F-1:0];
            p2_fy_reg    <= p1_py_reg[F-1:0];
            p2_wbank_reg <= {p1_row_reg[0], p1_col_reg[0]};
            p2_waddr_reg <= {HW'(p1_row_reg >> 1), HW'(p1_col_reg >> 1)};
            p2_pix_reg   <= p1_pix_reg;
        end
    end

    // stage 3: four banks by row and column parity
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0] bank_mem [BDEP];
        logic [2*HW-1:0]  raddr;

        assign raddr = {p2_hr_reg[b / 2], p2_hc_reg[b % 2]};

        always_ff @(posedge clk)
        begin
            if (en && p2_valid_reg && (p2_op_reg == OP_LOAD) && (p2_wbank_reg == 2'(b)))
            begin
                bank_mem[p2_waddr_reg] <= p2_pix_reg;
            end
            if (en)
            begin
                rd_reg[b] <= bank_mem[raddr];
            end
        end
    end

    logic [F:0] ofx, ofy;

    always_comb
    begin
        ofx = {1'b1, {F{1'b0}}} - {1'b0, p2_fx_reg};
        ofy = {1'b1, {F{1'b0}}} - {1'b0, p2_fy_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_req_reg <= (p2_op_reg == OP_REQ);
            p3_x0p_reg <= p2_x0p_reg;
            p3_x1p_reg <= p2_x1p_reg;
            p3_y0p_reg <= p2_y0p_reg;
            p3_y1p_reg <= p2_y1p_reg;
            p3_wa_reg  <= WW'(ofx * ofy);
            p3_wb_reg  <= WW'({1'b0, p2_fx_reg} * ofy);
            p3_wd_reg  <= WW'(ofx * {1'b0, p2_fy_reg});
            p3_wc_reg  <= WW'({1'b0, p2_fx_reg} * {1'b0, p2_fy_reg});
        end
    end

    // stage 4
    logic [PIX_W-1:0] nb [4];
    logic [WW-1:0]    wt [4];

    always_comb
    begin
        nb[0] = rd_reg[{p3_y0p_reg, p3_x0p_reg}];
        nb[1] = rd_reg[{p3_y0p_reg, p3_x1p_reg}];
        nb[2] = rd_reg[{p3_y1p_reg, p3_x0p_reg}];
        nb[3] = rd_reg[{p3_y1p_reg, p3_x1p_reg}];
        wt[0] = p3_wa_reg;
        wt[1] = p3_wb_reg;
        wt[2] = p3_wd_reg;
        wt[3] = p3_wc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    p4_prod_reg[k][n] <= PRW'(nb[n][PIX_W-1-CH_W*k -: CH_W] * wt[n]);
                end
            end
        end
    end

    // output: sum and truncate
    logic [SUMW-1:0] sum [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SUMW'(p4_prod_reg[k][0]) + SUMW'(p4_prod_reg[k][1]) +
                     SUMW'(p4_prod_reg[k][2]) + SUMW'(p4_prod_reg[k][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_r_reg <= sum[0][2*F +: CH_W];
            out_g_reg <= sum[1][2*F +: CH_W];
            out_b_reg <= sum[2][2*F +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= q_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg && p3_req_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_r_reg;
    assign out_green = out_g_reg;
    assign out_blue  = out_b_reg;

endmodule

>>> hw/rtl/bilinear_image_resize.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid / in_ready       | kind, pos_col, pos_row, in_red/green/blue
// out      | output    | out_valid / out_ready     | out_red, out_green, out_blue
// cfg      | input     | cfg_write (no wait)       | cfg_index, cfg_data
//
// One request per cycle sustained while the output does not stall; a resize result
// passes through the request queue, the back stages and the output register. The rate is
// set by the four-bank frame store (split by row and column parity), which returns all
// four neighbors in a single read. Reset clears control state and restores register
// defaults; the store is undefined until loaded. An output stall freezes the back
// pipeline; the four-entry request queue keeps accepting until full.
module bilinear_image_resize
    import bir_pkg::*;
#(
    parameter int MAX_SRC_SIDE = 256,
    parameter int FRAC_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [COORD_W-1:0]   pos_col,
    input  logic [COORD_W-1:0]   pos_row,
    input  logic [CH_W-1:0]      in_red,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= SIDE_W'(256);
            cfg_reg.src_height <= SIDE_W'(256);
            cfg_reg.step_x     <= STEP_W'(65536);
            cfg_reg.step_y     <= STEP_W'(65536);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[SIDE_W-1:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[SIDE_W-1:0];
                REG_STEP_X:     cfg_reg.step_x     <= cfg_data;
                REG_STEP_Y:     cfg_reg.step_y     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // front: classify and queue requests
    bir_front #(
        .MAX_SRC_SIDE(MAX_SRC_SIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .pos_col  (pos_col),
        .pos_row  (pos_row),
        .in_red   (in_red),
        .in_green (in_green),
        .in_blue  (in_blue),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // back: store access and blend pipeline
    bir_back #(
        .MAX_SRC_SIDE(MAX_SRC_SIDE),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule

>>> verif/bilinear_image_resize_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the resize engine,
// keeps its own copy of the frame store and registers, and checks every
// returned pixel against the oldest predicted one.
module bilinear_image_resize_checker
    import bir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 kind,
    input  logic [COORD_W-1:0]   pos_col,
    input  logic [COORD_W-1:0]   pos_row,
    input  logic [CH_W-1:0]      in_red,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_blue,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CH_W-1:0]      out_red,
    input  logic [CH_W-1:0]      out_green,
    input  logic [CH_W-1:0]      out_blue,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data,
    output int                   fails,
    output int                   pending
);

    localparam int SIDE = 256;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    logic [PIX_W-1:0]  src_px [0:SIDE*SIDE-1];
    logic [SIDE_W-1:0] m_width, m_height;
    logic [STEP_W-1:0] m_step_x, m_step_y;
    rgb_t              expected_px [$];

    function automatic logic [7:0] blend_chan(input logic [PIX_W-1:0] a, b, c, d,
                                              input int sh, input logic [63:0] wa, wb,
                                              wc, wd);
        logic [63:0] sum;
        begin
            sum = 64'((a >> sh) & 8'hFF) * wa + 64'((b >> sh) & 8'hFF) * wb
                + 64'((c >> sh) & 8'hFF) * wc + 64'((d >> sh) & 8'hFF) * wd;
            blend_chan = sum[39:32];
        end
    endfunction

    function automatic rgb_t resize_pixel(input logic [COORD_W-1:0] col, row);
        logic [63:0] w, h, px, py, ix, iy, fx, fy, x0, x1, y0, y1;
        logic [63:0] wa, wb, wc, wd;
        logic [PIX_W-1:0] a, b, c, d;
        rgb_t res;
        begin
            // zero sizes act as 1, oversize as the full store side
            w = (m_width == 0) ? 1 : (m_width > SIDE) ? SIDE : m_width;
            h = (m_height == 0) ? 1 : (m_height > SIDE) ? SIDE : m_height;
            px = 64'(col) * 64'(m_step_x);
            py = 64'(row) * 64'(m_step_y);
            ix = px >> 16;
            iy = py >> 16;
            fx = px & 64'hFFFF;
            fy = py & 64'hFFFF;
            x0 = (ix >= w - 1) ? w - 1 : ix;
            y0 = (iy >= h - 1) ? h - 1 : iy;
            x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
            a = src_px[y0 * SIDE + x0];
            b = src_px[y0 * SIDE + x1];
            c = src_px[y1 * SIDE + x1];
            d = src_px[y1 * SIDE + x0];
            wa = (65536 - fx) * (65536 - fy);
            wb = fx * (65536 - fy);
            wd = (65536 - fx) * fy;
            wc = fx * fy;
            res.red   = blend_chan(a, b, c, d, 16, wa, wb, wc, wd);
            res.green = blend_chan(a, b, c, d, 8, wa, wb, wc, wd);
            res.blue  = blend_chan(a, b, c, d, 0, wa, wb, wc, wd);
            resize_pixel = res;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        if (!rst_n)
        begin
            m_width  <= 9'd256;
            m_height <= 9'd256;
            m_step_x <= 24'h010000;
            m_step_y <= 24'h010000;
            expected_px.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_px.size() == 0)
                begin
                    $error("unexpected pixel %h %h %h", out_red, out_green, out_blue);
                    fails++;
                end
                else
                begin
                    want = expected_px.pop_front();
                    if (out_red !== want.red)
                    begin
                        $error("out_red expected %h actual %h", want.red, out_red);
                        fails++;
                    end
                    if (out_green !== want.green)
                    begin
                        $error("out_green expected %h actual %h", want.green, out_green);
                        fails++;
                    end
                    if (out_blue !== want.blue)
                    begin
                        $error("out_blue expected %h actual %h", want.blue, out_blue);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (kind == OP_REQ)
                    expected_px.push_back(resize_pixel(pos_col, pos_row));
                else if (pos_col < SIDE && pos_row < SIDE)
                    src_px[pos_row * SIDE + pos_col] = {in_red, in_green, in_blue};
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  m_width  <= cfg_data[SIDE_W-1:0];
                    REG_SRC_HEIGHT: m_height <= cfg_data[SIDE_W-1:0];
                    REG_STEP_X:     m_step_x <= cfg_data;
                    REG_STEP_Y:     m_step_y <= cfg_data;
                    default: ;
                endcase
            end
            pending = expected_px.size();
        end
    end

endmodule

>>> verif/bilinear_image_resize_tb.sv
`timescale 1ns / 1ps

// Testbench top: drives loads, resize requests and register writes into
// the engine; the checker beside it predicts and compares each pixel.
module bilinear_image_resize_tb;
    import bir_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [COORD_W-1:0]   pos_col;
    logic [COORD_W-1:0]   pos_row;
    logic [CH_W-1:0]      in_red, in_green, in_blue;
    logic                 out_valid;
    logic                 out_ready;
    logic [CH_W-1:0]      out_red, out_green, out_blue;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [STEP_W-1:0]    cfg_data;
    int                   fails;
    int                   pending;

    // idling enabled on both sides until the last stretch of the run
    bit idle_on;
    int req_count;
    int out_stall;

    bilinear_image_resize u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .pos_col(pos_col), .pos_row(pos_row),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bilinear_image_resize_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .pos_col(pos_col), .pos_row(pos_row),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result-side backpressure: random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // One request on the input channel; valid holds until accepted and
    // stays high into the next request when they follow back to back.
    task automatic send_item(input logic k, input logic [COORD_W-1:0] c, r,
                             input logic [PIX_W-1:0] px);
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid <= 1'b1;
            kind     <= k;
            pos_col  <= c;
            pos_row  <= r;
            {in_red, in_green, in_blue} <= px;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            req_count++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    // Drain all pending pixels, let loads in flight settle, then reprogram.
    task automatic program_regs(input int w, h, input logic [STEP_W-1:0] sx, sy);
        begin
            in_valid <= 1'b0;
            while (pending != 0) @(posedge clk);
            repeat (10) @(posedge clk);
            write_reg(REG_SRC_WIDTH, STEP_W'(w));
            write_reg(REG_SRC_HEIGHT, STEP_W'(h));
            write_reg(REG_STEP_X, sx);
            write_reg(REG_STEP_Y, sy);
            cfg_write <= 1'b0;
        end
    endtask

    // Program a source size, fill every pixel the blend can touch, then
    // fire resize requests. Out-of-store loads are mixed in as noise.
    task automatic resize_phase(input int w_reg, h_reg, input logic [STEP_W-1:0] sx, sy,
                                input int nreq);
        int ew, eh, c, r, n;
        begin
            ew = (w_reg == 0) ? 1 : (w_reg > 256) ? 256 : w_reg;
            eh = (h_reg == 0) ? 1 : (h_reg > 256) ? 256 : h_reg;
            program_regs(w_reg, h_reg, sx, sy);
            for (r = 0; r < eh; r++)
                for (c = 0; c < ew; c++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(OP_LOAD, COORD_W'($urandom_range(256, 4095)),
                                  COORD_W'($urandom_range(0, 4095)), PIX_W'($urandom));
                    if ($urandom_range(0, 15) == 0)
                        send_item(OP_LOAD, COORD_W'($urandom_range(0, 255)),
                                  COORD_W'($urandom_range(256, 4095)), PIX_W'($urandom));
                    // loaded beyond the configured size but inside the store
                    if (ew < 256 && $urandom_range(0, 15) == 0)
                        send_item(OP_LOAD, COORD_W'($urandom_range(ew, 255)),
                                  COORD_W'($urandom_range(0, 255)), PIX_W'($urandom));
                    send_item(OP_LOAD, COORD_W'(c), COORD_W'(r), PIX_W'($urandom));
                end
            for (n = 0; n < nreq; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_REQ, COORD_W'($urandom_range(0, 4095)),
                              COORD_W'($urandom_range(0, 4095)), PIX_W'($urandom));
                else
                    send_item(OP_REQ, COORD_W'($urandom_range(0, 2 * ew + 2)),
                              COORD_W'($urandom_range(0, 2 * eh + 2)), PIX_W'($urandom));
            end
        end
    endtask

    function automatic logic [STEP_W-1:0] pick_step(input int side);
        int dest;
        begin
            dest = $urandom_range(1, 16);
            if ($urandom_range(0, 1) == 0)
                pick_step = STEP_W'(((side - 1) << 16) / dest);
            else
                pick_step = STEP_W'($urandom_range(0, 24'hFF0000));
        end
    endfunction

    initial
    begin
        int w, h;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = OP_LOAD;
        pos_col   = '0;
        pos_row   = '0;
        in_red    = '0;
        in_green  = '0;
        in_blue   = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data  = '0;
        idle_on   = 1'b1;
        req_count = 0;
        out_stall = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: unit step, full store; only the top-left 2x2 is read.
        send_item(OP_LOAD, 12'd0, 12'd0, 24'hFFFFFF);
        send_item(OP_LOAD, 12'd1, 12'd0, 24'h000000);
        send_item(OP_LOAD, 12'd0, 12'd1, 24'hFF00FF);
        send_item(OP_LOAD, 12'd1, 12'd1, 24'h00FF00);
        send_item(OP_REQ, 12'd0, 12'd0, 24'hFFFFFF);

        // Directed: half-pixel blend, zero sizes, oversize width, tall
        // column, extreme and zero steps.
        resize_phase(2, 2, 24'h008000, 24'h008000, 4);
        resize_phase(0, 0, 24'hFF0000, 24'h000000, 3);
        resize_phase(511, 1, 24'h00FFFF, 24'hFF0000, 4);
        resize_phase(1, 256, 24'h000000, 24'h00FFFF, 4);
        resize_phase(3, 2, 24'hFF0000, 24'hFF0000, 3);

        while (req_count < 1000)
        begin
            if (req_count > 800)
                idle_on = 1'b0;
            if ($urandom_range(0, 9) < 7)
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                w = $urandom_range(0, 511);
                h = $urandom_range(0, 2);
            end
            else
            begin
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 511);
            end
            resize_phase(w, h, pick_step(w == 0 ? 1 : (w > 256 ? 256 : w)),
                         pick_step(h == 0 ? 1 : (h > 256 ? 256 : h)),
                         $urandom_range(10, 40));
        end

        idle_on = 1'b0;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("bilinear_image_resize_tb OK");
        else
            $display("bilinear_image_resize_tb NOT OK");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("bilinear_image_resize_tb NOT OK");
        $finish;
    end

endmodule
